FILE: src/cav_pkg.sv
// ----------------------------------------------------------------------------
// cav_pkg
// shared types, register indexes and helpers for the common average reference
// ----------------------------------------------------------------------------
package cav_pkg;

   // register indexes of the csr write port
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_EEG_MASK      = 2'd1;
   localparam logic [1:0] CSR_BAD_MASK      = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int COUNT_REG_BITS = 7;
   localparam int MASK_BITS      = 64;
   localparam int CHUNK_SIZE     = 8;

   // controller to datapath commands
   typedef struct packed {
      logic load;          // store sample, update good sum
      logic count_clear;   // clear good-channel count
      logic count_step;    // add one chunk of good bits to the count
      logic div_start;     // load divider from the sum, clear the sum
      logic div_step;      // one restoring division step
      logic div_finish;    // sign-correct quotient into the mean
      logic rd_issue;      // read one stored channel for emission
      logic rd_last;       // that channel closes the frame
   } cav_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic s1_free;       // read stage can take a new channel
      logic pipe_empty;    // no channel in flight toward the output
   } cav_status_type;

   // channel count as used: zero acts as one, above the maximum acts as maximum
   function automatic logic [COUNT_REG_BITS-1:0] cav_eff_count(
      input logic [COUNT_REG_BITS-1:0] raw,
      input int unsigned               max_ch
   );
      logic [COUNT_REG_BITS-1:0] result;
      if (raw == '0) begin
         result = COUNT_REG_BITS'(1);
      end else if (raw > max_ch) begin
         result = COUNT_REG_BITS'(max_ch);
      end else begin
         result = raw;
      end
      return result;
   endfunction

endpackage

FILE: src/cav_req_if.sv
// ----------------------------------------------------------------------------
// cav_req_if
// sample channel: one converter sample per transaction
// ----------------------------------------------------------------------------
interface cav_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: src/cav_rsp_if.sv
// ----------------------------------------------------------------------------
// cav_rsp_if
// result channel: one referenced channel sample per transaction
// ----------------------------------------------------------------------------
interface cav_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] referenced_sample;
   logic                        last_of_frame;

   modport source (output valid, output referenced_sample, output last_of_frame, input ready);
   modport sink   (input valid, input referenced_sample, input last_of_frame, output ready);
endinterface

FILE: src/common_average_reference.sv
// ----------------------------------------------------------------------------
// common_average_reference
// eeg common average re-referencing of one multichannel frame
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                              meaning
//   req_ch   in         sample                               one sample, channel order
//   rsp_ch   out        referenced_sample, last_of_frame     one channel of the frame
//   csr_*    in         csr_index, csr_write_data            count and mask registers
//
// a frame of N channels is loaded, then its good channels are counted in chunks
// of eight, the divider is loaded from the sum, a bit-serial restoring division
// runs and the quotient is sign-fixed, then the N channels are emitted; the
// serial divider sets the overhead
// loading of the next frame overlaps the tail of the emission, but its division
// waits until the last result of the previous frame has been taken
// synchronous active-high reset: masks and count return to their defaults, sum cleared
// a stalled result holds in the output register while the read stage keeps one more
//
module common_average_reference import cav_pkg::*; #(
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 24,
   localparam int IDX_BITS    = $clog2(MAX_CHANNELS),
   localparam int CNT_BITS    = $clog2(MAX_CHANNELS + 1),
   localparam int NCHUNK      = (MAX_CHANNELS + CHUNK_SIZE - 1) / CHUNK_SIZE,
   localparam int CHUNK_BITS  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
   localparam int OUT_BITS    = SAMPLE_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   cav_req_if.sink                   req_ch,
   cav_rsp_if.source                 rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   // configuration registers
   logic [COUNT_REG_BITS-1:0] count_ff, count_in;
   logic [MASK_BITS-1:0]      eeg_mask_ff, eeg_mask_in;
   logic [MASK_BITS-1:0]      bad_mask_ff, bad_mask_in;
   logic [CNT_BITS-1:0]       count_eff;

   // controller and datapath link
   cav_cmd_type               cmd;
   cav_status_type            status;
   logic [IDX_BITS-1:0]       addr;
   logic [CHUNK_BITS-1:0]     chunk;

   logic                      rsp_valid;
   logic signed [OUT_BITS-1:0] rsp_data;
   logic                      rsp_last;

   // register writes; an index past the list is dropped
   always_comb begin
      count_in    = count_ff;
      eeg_mask_in = eeg_mask_ff;
      bad_mask_in = bad_mask_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: count_in    = COUNT_REG_BITS'(csr_write_data);
            CSR_EEG_MASK:      eeg_mask_in = csr_write_data;
            CSR_BAD_MASK:      bad_mask_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= COUNT_REG_BITS'(MAX_CHANNELS);
         eeg_mask_ff <= '1;
         bad_mask_ff <= '0;
      end else begin
         count_ff    <= count_in;
         eeg_mask_ff <= eeg_mask_in;
         bad_mask_ff <= bad_mask_in;
      end
   end

   // clamp the programmed count into 1..MAX_CHANNELS
   assign count_eff = CNT_BITS'(cav_eff_count(count_ff, MAX_CHANNELS));

   cav_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .count     (count_eff),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd),
      .addr      (addr),
      .chunk     (chunk)
   );

   cav_dpath #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr      (addr),
      .chunk     (chunk),
      .count     (count_eff),
      .eeg_mask  (eeg_mask_ff),
      .bad_mask  (bad_mask_ff),
      .sample    (req_ch.sample),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

   // result channel
   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.referenced_sample = rsp_data;
   assign rsp_ch.last_of_frame     = rsp_last;

   // the mean is only reloaded once no channel of the old frame is in flight
   a_div_after_drain: assert property (
      @(posedge clock) disable iff (reset) cmd.div_start |-> status.pipe_empty
   ) else $error("division started with results still in flight");

   // a store read never overruns the read stage
   a_read_has_room: assert property (
      @(posedge clock) disable iff (reset) cmd.rd_issue |-> status.s1_free
   ) else $error("store read issued into a full read stage");

   // loading and emission never share the store address
   a_no_load_during_emit: assert property (
      @(posedge clock) disable iff (reset) (req_ch.valid && req_ch.ready) |-> !cmd.rd_issue
   ) else $error("sample accepted during emission");

   // one sequencer phase at a time
   a_one_phase: assert property (
      @(posedge clock) disable iff (reset)
         $onehot0({cmd.load, cmd.count_step, cmd.div_step, cmd.rd_issue})
   ) else $error("more than one sequencer phase active");

endmodule

FILE: src/cav_ram.sv
// ----------------------------------------------------------------------------
// cav_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cav_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cav_ctrl.sv
// ----------------------------------------------------------------------------
// cav_ctrl
// frame sequencer: load, good-channel count, division, emission
// ----------------------------------------------------------------------------
module cav_ctrl import cav_pkg::*; #(
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 24,
   localparam int IDX_BITS    = $clog2(MAX_CHANNELS),
   localparam int CNT_BITS    = $clog2(MAX_CHANNELS + 1),
   localparam int NCHUNK      = (MAX_CHANNELS + CHUNK_SIZE - 1) / CHUNK_SIZE,
   localparam int CHUNK_BITS  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS),
   localparam int STEP_BITS   = $clog2(SUM_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_BITS-1:0]   count,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cav_status_type        status,
   output cav_cmd_type           cmd,
   output logic [IDX_BITS-1:0]   addr,
   output logic [CHUNK_BITS-1:0] chunk
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COUNT,
      ST_HOLD,
      ST_DIVIDE,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   addr_ff, addr_in;
   logic [CHUNK_BITS-1:0] chunk_ff, chunk_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [CNT_BITS-1:0]   addr_plus;
   logic                  frame_end;

   assign addr_plus = CNT_BITS'(addr_ff) + CNT_BITS'(1);
   assign frame_end = (addr_plus >= count);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      chunk_in = chunk_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (frame_end) begin
                  addr_in         = '0;
                  chunk_in        = '0;
                  cmd.count_clear = 1'b1;
                  state_in        = ST_COUNT;
               end else begin
                  addr_in = IDX_BITS'(addr_plus);
               end
            end
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (chunk_ff == CHUNK_BITS'(NCHUNK - 1)) begin
               state_in = ST_HOLD;
            end else begin
               chunk_in = chunk_ff + CHUNK_BITS'(1);
            end
         end
         ST_HOLD: begin
            // the mean may change only once the previous frame has drained
            if (status.pipe_empty) begin
               cmd.div_start = 1'b1;
               step_in       = '0;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_FINISH: begin
            cmd.div_finish = 1'b1;
            addr_in        = '0;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.s1_free) begin
               cmd.rd_issue = 1'b1;
               cmd.rd_last  = frame_end;
               if (frame_end) begin
                  addr_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  addr_in = IDX_BITS'(addr_plus);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         addr_ff  <= '0;
         chunk_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         chunk_ff <= chunk_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign addr      = addr_ff;
   assign chunk     = chunk_ff;

endmodule

FILE: src/cav_dpath.sv
// ----------------------------------------------------------------------------
// cav_dpath
// frame store, good sum, good count, serial divider and output pipeline
// ----------------------------------------------------------------------------
module cav_dpath import cav_pkg::*; #(
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 24,
   localparam int IDX_BITS    = $clog2(MAX_CHANNELS),
   localparam int CNT_BITS    = $clog2(MAX_CHANNELS + 1),
   localparam int NCHUNK      = (MAX_CHANNELS + CHUNK_SIZE - 1) / CHUNK_SIZE,
   localparam int CHUNK_BITS  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_CHANNELS),
   localparam int WIDE_BITS   = SUM_BITS + 1,
   localparam int OUT_BITS    = SAMPLE_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cav_cmd_type                  cmd,
   input  logic [IDX_BITS-1:0]          addr,
   input  logic [CHUNK_BITS-1:0]        chunk,
   input  logic [CNT_BITS-1:0]          count,
   input  logic [MASK_BITS-1:0]         eeg_mask,
   input  logic [MASK_BITS-1:0]         bad_mask,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output cav_status_type               status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_BITS-1:0]   rsp_data,
   output logic                         rsp_last
);

   localparam logic signed [WIDE_BITS-1:0] SAT_HI =
      WIDE_BITS'((longint'(1) <<< SAMPLE_BITS) - longint'(1));
   localparam logic signed [WIDE_BITS-1:0] SAT_LO = -SAT_HI;

   // good sum and count
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [CNT_BITS-1:0]         ngood_ff, ngood_in;
   logic [MASK_BITS-1:0]        good_vec;
   logic [CHUNK_SIZE-1:0]       good_byte;
   logic [3:0]                  byte_pop;
   logic                        load_good;

   // divider
   logic                        div_neg_ff, div_neg_in;
   logic [CNT_BITS-1:0]         div_rem_ff, div_rem_in;
   logic [SUM_BITS-1:0]         div_q_ff, div_q_in;
   logic [CNT_BITS:0]           rem_sh;
   logic                        rem_ge;
   logic signed [SUM_BITS-1:0]  mean_ff, mean_in;

   // emission pipeline
   logic [SAMPLE_BITS-1:0]      ram_q;
   logic                        s1_valid_ff, s1_valid_in;
   logic [IDX_BITS-1:0]         s1_ch_ff;
   logic                        s1_last_ff;
   logic                        out_valid_ff, out_valid_in;
   logic signed [OUT_BITS-1:0]  out_data_ff;
   logic                        out_last_ff;
   logic                        out_load;
   logic signed [SAMPLE_BITS-1:0] s1_sample;
   logic signed [WIDE_BITS-1:0] diff;
   logic signed [WIDE_BITS-1:0] diff_sat;
   logic signed [OUT_BITS-1:0]  s1_result;
   logic                        s1_eeg;
   logic                        s1_good;

   cav_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_CHANNELS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (addr),
      .wr_data (sample),
      .rd_en   (cmd.rd_issue),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   // good bits of the channels below the count
   always_comb begin
      for (int i = 0; i < MASK_BITS; i++) begin
         good_vec[i] = eeg_mask[i] & ~bad_mask[i] & (i < count);
      end
   end

   assign good_byte = CHUNK_SIZE'(good_vec >> {chunk, 3'b000});

   always_comb begin
      byte_pop = '0;
      for (int b = 0; b < CHUNK_SIZE; b++) begin
         byte_pop = byte_pop + 4'(good_byte[b]);
      end
   end

   assign load_good = eeg_mask[addr] & ~bad_mask[addr];

   always_comb begin
      sum_in = sum_ff;
      if (cmd.div_start) begin
         sum_in = '0;
      end else if (cmd.load && load_good) begin
         sum_in = sum_ff + SUM_BITS'(sample);
      end
   end

   always_comb begin
      ngood_in = ngood_ff;
      if (cmd.count_clear) begin
         ngood_in = '0;
      end else if (cmd.count_step) begin
         ngood_in = ngood_ff + CNT_BITS'(byte_pop);
      end
   end

   // restoring division of the sum magnitude, one quotient bit per step
   assign rem_sh = {div_rem_ff, div_q_ff[SUM_BITS-1]};
   assign rem_ge = (rem_sh >= {1'b0, ngood_ff});

   always_comb begin
      div_neg_in = div_neg_ff;
      div_rem_in = div_rem_ff;
      div_q_in   = div_q_ff;
      mean_in    = mean_ff;
      if (cmd.div_start) begin
         div_neg_in = sum_ff[SUM_BITS-1];
         div_rem_in = '0;
         div_q_in   = sum_ff[SUM_BITS-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      end else if (cmd.div_step) begin
         div_rem_in = rem_ge ? CNT_BITS'(rem_sh - {1'b0, ngood_ff}) : CNT_BITS'(rem_sh);
         div_q_in   = {div_q_ff[SUM_BITS-2:0], rem_ge};
      end
      if (cmd.div_finish) begin
         if (ngood_ff == '0) begin
            mean_in = '0;
         end else if (div_neg_ff) begin
            mean_in = -$signed(div_q_ff);
         end else begin
            mean_in = $signed(div_q_ff);
         end
      end
   end

   // referenced value of the channel in the read stage
   assign s1_sample = $signed(ram_q);
   assign s1_eeg    = eeg_mask[s1_ch_ff];
   assign s1_good   = s1_eeg & ~bad_mask[s1_ch_ff];
   assign diff      = WIDE_BITS'(s1_sample) - WIDE_BITS'(mean_ff);

   always_comb begin
      if (diff > SAT_HI) begin
         diff_sat = SAT_HI;
      end else if (diff < SAT_LO) begin
         diff_sat = SAT_LO;
      end else begin
         diff_sat = diff;
      end
      if (!s1_eeg) begin
         s1_result = OUT_BITS'(s1_sample);
      end else if (s1_good) begin
         s1_result = OUT_BITS'(diff_sat);
      end else begin
         s1_result = '0;
      end
   end

   assign out_load = s1_valid_ff & (~out_valid_ff | rsp_ready);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (cmd.rd_issue) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ngood_ff   <= ngood_in;
      div_neg_ff <= div_neg_in;
      div_rem_ff <= div_rem_in;
      div_q_ff   <= div_q_in;
      mean_ff    <= mean_in;
      if (cmd.rd_issue) begin
         s1_ch_ff   <= addr;
         s1_last_ff <= cmd.rd_last;
      end
      if (out_load) begin
         out_data_ff <= s1_result;
         out_last_ff <= s1_last_ff;
      end
   end

   assign status.s1_free    = ~s1_valid_ff | out_load;
   assign status.pipe_empty = ~s1_valid_ff & ~out_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_last  = out_last_ff;

endmodule

FILE: test/common_average_reference_tb.sv
// ----------------------------------------------------------------------------
// common_average_reference_tb
// self-checking bench for eeg common average re-referencing
//
// a frame checker predicts every channel of every frame from the accepted
// samples and the register writes, and compares each result transaction
// with the oldest prediction. short directed frames cover the sample
// extremes, bad and non-eeg channels, frames with no good channel, the
// count of zero, a count lowered and masks changed mid-frame with
// saturation both ways, and a write to an unused register index. random
// frames follow under random counts and masks, with random gaps on both
// channels and some frames broken by a register change part way through
// ----------------------------------------------------------------------------
module common_average_reference_tb;
   import cav_pkg::*;

   localparam int MAX_CHANNELS = 64;
   localparam int SAMPLE_BITS  = 24;
   localparam int OUT_BITS     = SAMPLE_BITS + 1;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   // results are clamped to this magnitude
   localparam longint SAT_LIMIT = (longint'(1) << SAMPLE_BITS) - 1;

   // index outside the register map, writes to it must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   // count, division and a full emission of 64 channels, with margin
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEM_TARGET    = 124;

   // one expected result transaction
   typedef struct packed {
      logic signed [OUT_BITS-1:0] referenced_sample;
      logic                       last_of_frame;
   } referenced_channel_type;

   // ------------------------------------------------------------------------
   // frame checker: own copy of registers and frame state, queue of
   // predicted channels, mismatch count
   // ------------------------------------------------------------------------
   class frame_checker_type;
      logic [COUNT_REG_BITS-1:0]     channel_count;
      logic [MASK_BITS-1:0]          eeg_mask;
      logic [MASK_BITS-1:0]          bad_mask;
      logic signed [SAMPLE_BITS-1:0] frame_store [MAX_CHANNELS];
      longint                        good_sum;
      int unsigned                   channel_counter;
      referenced_channel_type        pending_channels [$];
      int unsigned                   mismatches;

      function new();
         channel_count   = COUNT_REG_BITS'(MAX_CHANNELS);
         eeg_mask        = '1;
         bad_mask        = '0;
         good_sum        = 0;
         channel_counter = 0;
         mismatches      = 0;
         foreach (frame_store[i]) frame_store[i] = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_CHANNEL_COUNT: channel_count = value[COUNT_REG_BITS-1:0];
            CSR_EEG_MASK:      eeg_mask = value;
            CSR_BAD_MASK:      bad_mask = value;
            default: ;
         endcase
      endfunction

      // zero acts as one, above the maximum acts as the maximum
      function int unsigned frame_length();
         if (channel_count == 0) return 1;
         if (channel_count > MAX_CHANNELS) return MAX_CHANNELS;
         return channel_count;
      endfunction

      function bit is_good(int unsigned ch);
         return eeg_mask[ch] && !bad_mask[ch];
      endfunction

      // samples still needed to close the open frame
      function int unsigned samples_to_close();
         int unsigned len;
         len = frame_length();
         return (channel_counter >= len) ? 1 : len - channel_counter;
      endfunction

      function void take_sample(logic signed [SAMPLE_BITS-1:0] s);
         int unsigned            len;
         int unsigned            slot;
         int unsigned            good_count;
         int unsigned            ch;
         longint                 mean;
         longint                 v;
         referenced_channel_type r;
         len  = frame_length();
         slot = channel_counter % MAX_CHANNELS;
         frame_store[slot] = s;
         // sum uses the masks in force as the sample arrives
         if (is_good(slot)) good_sum += s;
         channel_counter = slot + 1;
         if (channel_counter < len) return;
         // count and decisions use the masks in force at emission
         good_count = 0;
         for (ch = 0; ch < len; ch++)
            if (is_good(ch)) good_count++;
         mean = (good_count != 0) ? good_sum / longint'(good_count) : 0;
         for (ch = 0; ch < len; ch++) begin
            if (!eeg_mask[ch]) begin
               v = frame_store[ch];
            end else if (is_good(ch)) begin
               v = frame_store[ch] - mean;
            end else begin
               v = 0;
            end
            if (v > SAT_LIMIT) v = SAT_LIMIT;
            if (v < -SAT_LIMIT) v = -SAT_LIMIT;
            r.referenced_sample = v[OUT_BITS-1:0];
            r.last_of_frame     = (ch + 1 == len);
            pending_channels.push_back(r);
         end
         good_sum        = 0;
         channel_counter = 0;
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_channel(logic signed [OUT_BITS-1:0] value, logic last);
         referenced_channel_type want;
         if (pending_channels.size() == 0) begin
            report($sformatf("unexpected transaction: sample %0d last %0b", value, last));
            return;
         end
         want = pending_channels.pop_front();
         if (value !== want.referenced_sample || last !== want.last_of_frame)
            report($sformatf("expected sample %0d last %0b, got sample %0d last %0b",
                             want.referenced_sample, want.last_of_frame, value, last));
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   cav_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
   cav_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_bus ();

   frame_checker_type frame_check = new();

   // no-gap stretches, redrawn for each phase of the run
   bit          sample_burst;
   bit          result_burst;
   int unsigned samples_sent;
   int unsigned quiet_cycles;

   always #10 clock = ~clock;

   common_average_reference #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (sample_bus),
      .rsp_ch          (result_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // ------------------------------------------------------------------------
   // monitor: every accepted transaction on either channel goes to the
   // checker; cycles with no transaction feed the watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) begin
         frame_check.take_sample(sample_bus.sample);
         quiet_cycles = 0;
      end else if (!reset && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (!reset && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
         frame_check.check_channel(result_bus.referenced_sample, result_bus.last_of_frame);
   end

   // watchdog: a hang or a missing result ends the run as a failure
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stall before taking each transaction
   initial begin
      int stall;
      result_bus.ready = 1'b0;
      forever begin
         stall = result_burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            result_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         result_bus.ready <= 1'b1;
         do @(posedge clock); while (result_bus.valid !== 1'b1);
      end
   end

   // ------------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------------

   // one sample transaction after a random gap; valid stays high when the
   // next one follows without a gap
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = sample_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         sample_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sample_bus.valid  <= 1'b1;
      sample_bus.sample <= value;
      do @(posedge clock); while (sample_bus.ready !== 1'b1);
      samples_sent++;
   endtask

   // drain every predicted result, then give the block time to finish
   // any work that produces nothing (counting, division)
   task automatic settle();
      sample_bus.valid <= 1'b0;
      do @(negedge clock); while (frame_check.pending_channels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only called while the block is idle
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0]  value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frame_check.write_register(index, value);
      @(posedge clock);
   endtask

   // extremes now and then, otherwise any value
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [COUNT_REG_BITS-1:0] count_value;
      logic [CSR_DATA_BITS-1:0]  data;
      int unsigned               len;
      int unsigned               partial;
      int unsigned               frames;
      int unsigned               f;
      int unsigned               phase;

      reset             = 1'b1;
      sample_bus.valid  = 1'b0;
      sample_bus.sample = '0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      sample_burst      = 1'b0;
      result_burst      = 1'b0;
      samples_sent      = 0;
      quiet_cycles      = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----

      // reset count is the full frame, so three samples leave it open
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_BITS'(-1));
      settle();
      // count lowered below the counter: next sample is stored and closes
      // the frame, only channels 0 and 1 are emitted
      write_register(CSR_CHANNEL_COUNT, 64'd2);
      send_sample('0);
      settle();

      // unused index must not disturb any register
      write_register(CSR_UNUSED_INDEX, '0);
      // channel 3 non-eeg, channel 1 bad; good sum is negative and odd so
      // the mean truncates toward zero
      write_register(CSR_CHANNEL_COUNT, 64'd4);
      write_register(CSR_EEG_MASK, 64'h7);
      write_register(CSR_BAD_MASK, 64'h2);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(24'sd3);
      send_sample(SAMPLE_MIN);
      settle();

      // no good channel: eeg channels give zero, channel 3 still passes
      write_register(CSR_BAD_MASK, '1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_BITS'(-1));
      send_sample(24'h5A5A5A);
      send_sample(SAMPLE_MAX);
      settle();

      // count of zero acts as one; upper data bits are not part of the count
      write_register(CSR_CHANNEL_COUNT, 64'hFFFF_FFFF_FFFF_FF80);
      write_register(CSR_EEG_MASK, '1);
      write_register(CSR_BAD_MASK, '0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      settle();

      // masks changed mid-frame: three minimum samples enter the sum, then
      // only channel 3 stays good, so its result overflows upward
      write_register(CSR_CHANNEL_COUNT, 64'd4);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      settle();
      write_register(CSR_BAD_MASK, 64'h7);
      send_sample(SAMPLE_MAX);
      settle();
      // same the other way: saturation at the negative bound
      write_register(CSR_BAD_MASK, '0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      settle();
      write_register(CSR_BAD_MASK, 64'h7);
      send_sample(SAMPLE_MIN);

      // ---- random part ----
      phase = 0;
      while (samples_sent < ITEM_TARGET) begin
         settle();
         phase++;
         sample_burst = ($urandom_range(0, 3) == 0);
         result_burst = ($urandom_range(0, 3) == 0);

         // mostly short frames; the first phase takes an out-of-range count
         // that acts as the full frame
         case ($urandom_range(0, 9))
            0:       count_value = '0;
            1:       count_value = COUNT_REG_BITS'($urandom_range(13, 40));
            default: count_value = COUNT_REG_BITS'($urandom_range(1, 12));
         endcase
         if (phase == 1) count_value = COUNT_REG_BITS'($urandom_range(65, 127));
         data = {$urandom, $urandom};
         data[COUNT_REG_BITS-1:0] = count_value;
         write_register(CSR_CHANNEL_COUNT, data);

         data = {$urandom, $urandom};
         if ($urandom_range(0, 2) == 0) data = '1;
         write_register(CSR_EEG_MASK, data);

         // bad channels are mostly sparse, sometimes none or all
         case ($urandom_range(0, 4))
            0:       data = '0;
            1:       data = '1;
            default: data = {$urandom, $urandom} & {$urandom, $urandom};
         endcase
         write_register(CSR_BAD_MASK, data);

         if ($urandom_range(0, 7) == 0)
            write_register(CSR_UNUSED_INDEX, {$urandom, $urandom});

         // one full-length frame in the first phase keeps the run near its size
         frames = (phase == 1) ? 1 : $urandom_range(1, 3);
         for (f = 0; f < frames && samples_sent < ITEM_TARGET; f++) begin
            len = frame_check.frame_length();
            if (len > 1 && $urandom_range(0, 3) == 0) begin
               // broken frame: stop part way, change a register, then send
               // whatever the frame still needs
               partial = $urandom_range(1, len - 1);
               repeat (partial) send_sample(random_sample());
               settle();
               if ($urandom_range(0, 1) == 0)
                  write_register(CSR_CHANNEL_COUNT, 64'($urandom_range(1, partial)));
               else
                  write_register(CSR_BAD_MASK, {$urandom, $urandom});
               repeat (frame_check.samples_to_close()) send_sample(random_sample());
            end else begin
               repeat (len) send_sample(random_sample());
            end
         end
      end

      // drain and watch a little longer for stray results
      settle();
      if (frame_check.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
